// ===== rtl/ttl_pkg.sv =====
// Package for the token table: sizes, field layout, operation codes and the
// types passed between the engine, the RAM and the top level.
// No dependencies.
`default_nettype none

package ttl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int TOKEN_W = 64;
  localparam int TIME_W  = 31;
  localparam int EXP_W   = 32;
  localparam int LIVE_W  = 5;

  // Derived widths
  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = KEY_BITS + EXP_W;

  // Stream packing: fields from the low bit up, padded to whole bytes
  localparam int IN_W        = FUNC_W + TOKEN_W + TIME_W;
  localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = LIVE_W + 1;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  // Operation codes; the spare code is a no-op
  typedef enum logic [FUNC_W-1:0] {
    FUNC_GENERATE = 2'd0,
    FUNC_RENEW    = 2'd1,
    FUNC_COUNT    = 2'd2
  } func_e;

  // One table slot as held in the RAM
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [EXP_W-1:0]    expiry;
  } entry_t;

  // Result item, live_count in the low bits
  typedef struct packed {
    logic              status;
    logic [LIVE_W-1:0] live_count;
  } result_t;

  // RAM access issued by the engine
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/ttl_token_table.sv =====
// Top level of the token table: stream ports, lifetime register, output
// register, engine and slot RAM. Depends on ttl_pkg, ttl_engine, ttl_ram.
//
//  Channel  Direction  Contents (low bit first)
//  s_axis   in         func[1:0], token_key[65:2], now[96:66], zero pad
//  m_axis   out        live_count[4:0], status[5], zero pad
//  cfg      in         time_to_live[30:0], written when cfg_we_i is high
//
// Generate and the spare code go via the done state to the output register;
// renew and count scan up to fill slots, one slot per cycle, set by the
// single read port of the slot RAM. One item is in work at a time; the next
// is taken once the result has moved to the output register, which holds it
// while m_axis_tready is low. Reset clears the fill count; no clearing pass.
`default_nettype none

module ttl_token_table (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // func, token_key, now
  input  wire logic [ttl_pkg::IN_BYTES_W-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // live_count, status
  output logic      [ttl_pkg::OUT_BYTES_W-1:0]    m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [ttl_pkg::TIME_W-1:0]         cfg_wdata_i
);

  import ttl_pkg::*;

  logic [TIME_W-1:0]  ttl_q;
  logic               m_valid_q;
  result_t            m_data_q;

  logic [TOKEN_W-1:0] in_token;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  assign in_token = s_axis_tdata[FUNC_W +: TOKEN_W];

  // Lifetime register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TIME_W'(1);
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  ttl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_func_i  (s_axis_tdata[FUNC_W-1:0]),
    .req_key_i   (in_token[KEY_BITS-1:0]),
    .req_now_i   (s_axis_tdata[FUNC_W+TOKEN_W +: TIME_W]),
    .ttl_i       (ttl_q),
    .mem_req_o   (mem_req),
    .mem_rdata_i (entry_t'(mem_rdata)),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ttl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_BYTES_W'(m_data_q);

endmodule

`default_nettype wire

// ===== rtl/ttl_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ttl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ttl_engine.sv =====
// Sequencer for the token table: appends, walks the RAM for renew and
// compacts it for count, one RAM read per cycle.
// Depends on ttl_pkg.
`default_nettype none

module ttl_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic [ttl_pkg::FUNC_W-1:0]    req_func_i,
  input  wire logic [ttl_pkg::KEY_BITS-1:0]  req_key_i,
  input  wire logic [ttl_pkg::TIME_W-1:0]    req_now_i,
  input  wire logic [ttl_pkg::TIME_W-1:0]    ttl_i,
  output ttl_pkg::mem_req_t                  mem_req_o,
  input  wire ttl_pkg::entry_t               mem_rdata_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output ttl_pkg::result_t                   res_o
);

  import ttl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  result_t             res_q, res_d;

  func_e               op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [EXP_W-1:0]    fresh_q, fresh_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FILL_W-1:0]   live_q, live_d;

  logic [FILL_W-1:0]   live_nxt;
  logic                is_live;
  logic                key_hit;
  mem_req_t            mem_req;

  // Slot under test, read in the previous cycle
  assign is_live = mem_rdata_i.expiry > {1'b0, now_q};
  assign key_hit = mem_rdata_i.key == key_q;
  assign live_nxt = is_live ? live_q + FILL_W'(1) : live_q;

  // Next state and RAM requests
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    res_d   = res_q;
    op_d    = op_q;
    key_d   = key_q;
    now_d   = now_q;
    fresh_d = fresh_q;
    idx_d   = idx_q;
    live_d  = live_q;
    mem_req = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d    = func_e'(req_func_i);
          key_d   = req_key_i;
          now_d   = req_now_i;
          fresh_d = {1'b0, req_now_i} + {1'b0, ttl_i};
          live_d  = '0;
          res_d   = '0;
          state_d = ST_DONE;
          case (func_e'(req_func_i))
            FUNC_GENERATE: begin
              if (fill_q == FILL_W'(TABLE_DEPTH)) begin
                res_d.status = 1'b1;
              end else begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = fill_q[IDX_W-1:0];
                mem_req.wdata.key    = req_key_i;
                mem_req.wdata.expiry = fresh_d;
                fill_d               = fill_q + FILL_W'(1);
              end
            end
            FUNC_RENEW: begin
              // newest first
              if (fill_q != '0) begin
                mem_req.raddr = IDX_W'(fill_q - FILL_W'(1));
                idx_d         = IDX_W'(fill_q - FILL_W'(1));
                state_d       = ST_SCAN;
              end
            end
            FUNC_COUNT: begin
              // oldest first
              if (fill_q != '0) begin
                mem_req.raddr = '0;
                idx_d         = '0;
                state_d       = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        case (op_q)
          FUNC_RENEW: begin
            if (key_hit && is_live) begin
              mem_req.we           = 1'b1;
              mem_req.waddr        = idx_q;
              mem_req.wdata.key    = key_q;
              mem_req.wdata.expiry = fresh_q;
              state_d              = ST_DONE;
            end else if (idx_q == '0) begin
              state_d = ST_DONE;
            end else begin
              mem_req.raddr = idx_q - IDX_W'(1);
              idx_d         = idx_q - IDX_W'(1);
            end
          end
          default: begin
            // compaction: survivors move down to the live pointer, which
            // never passes the read pointer
            if (is_live) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = live_q[IDX_W-1:0];
              mem_req.wdata = mem_rdata_i;
            end
            live_d = live_nxt;
            if (FILL_W'(idx_q) + FILL_W'(1) == fill_q) begin
              fill_d           = live_nxt;
              res_d.live_count = LIVE_W'(live_nxt);
              state_d          = ST_DONE;
            end else begin
              mem_req.raddr = idx_q + IDX_W'(1);
              idx_d         = idx_q + IDX_W'(1);
            end
          end
        endcase
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, fill count and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      res_q   <= res_d;
    end
  end

  // Request payload and scan pointers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    now_q   <= now_d;
    fresh_q <= fresh_d;
    idx_q   <= idx_d;
    live_q  <= live_d;
  end

  assign req_ready_o = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign res_o       = res_q;
  assign mem_req_o   = mem_req;

endmodule

`default_nettype wire

// ===== rtl/ttl_checker.sv =====
// Port-level checks for the token table, bound to the top level.
// Depends on ttl_pkg and ttl_token_table.
`default_nettype none

module ttl_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [ttl_pkg::OUT_BYTES_W-1:0] m_axis_tdata
);

  import ttl_pkg::*;

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item withdrawn under stall");

  // A stalled item keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed under stall");

  // Only one item in work: the input closes after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // A dropped generate reports no count
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[LIVE_W] |-> m_axis_tdata[LIVE_W-1:0] == '0)
    else $error("full flag with non-zero count");

  // Count never exceeds the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (TABLE_DEPTH > 31) ||
                      (m_axis_tdata[LIVE_W-1:0] <= LIVE_W'(TABLE_DEPTH)))
    else $error("count beyond table size");

endmodule

bind ttl_token_table ttl_checker u_ttl_checker (.*);

`default_nettype wire

// ===== tb/tb_ttl_token_table.sv =====
// Self-checking testbench for the token table: directed table of requests,
// then phased random traffic checked against a predictor of the table.
// Depends on ttl_pkg and ttl_token_table.
`timescale 1ns / 100ps

module tb_ttl_token_table;

  import ttl_pkg::*;

  localparam logic [FUNC_W-1:0]  FUNC_SPARE    = 2'd3;
  localparam logic [TOKEN_W-1:0] KEY_ONES      = {TOKEN_W{1'b1}};
  localparam logic [TIME_W-1:0]  TIME_MAX      = {TIME_W{1'b1}};
  localparam int                 LATENCY_SLACK = TABLE_DEPTH + 4;
  localparam int                 N_PHASES      = 6;
  localparam int                 PHASE_ITEMS   = 85;
  localparam int                 HOLD_AT       = 250;
  localparam int                 HOLD_CYCLES   = 400;

  // One row of the directed table
  typedef struct packed {
    bit                  lifetime_wr;
    logic [TIME_W-1:0]   lifetime_val;
    logic [FUNC_W-1:0]   op;
    logic [TOKEN_W-1:0]  key;
    logic [TIME_W-1:0]   now;
    bit                  typed;
    logic [LIVE_W-1:0]   live;
    logic                status;
  } directed_row_t;

  localparam int N_DIRECTED = 27;
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // empty table, spare code, extremes of key and time
    '{1'b0, 31'd0, FUNC_COUNT,    64'd0,                   31'd0,    1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_RENEW,    KEY_ONES,                TIME_MAX, 1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_SPARE,    KEY_ONES,                TIME_MAX, 1'b1, 5'd0,  1'b0},
    // fill the table, a duplicate key among them
    '{1'b0, 31'd0, FUNC_GENERATE, 64'd0,                   31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, KEY_ONES,                31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h5555_5555_5555_5555, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'd0,                   31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'd1,                   31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h8000_0000_0000_0000, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h7FFF_FFFF_FFFF_FFFF, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h0123_4567_89AB_CDEF, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'hFEDC_BA98_7654_3210, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h0F0F_0F0F_0F0F_0F0F, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'hF0F0_F0F0_F0F0_F0F0, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h3333_3333_3333_3333, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'hCCCC_CCCC_CCCC_CCCC, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'h0000_0000_FFFF_FFFF, 31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_GENERATE, 64'hFFFF_FFFF_0000_0000, 31'd100,  1'b1, 5'd0,  1'b0},
    // full table drops the request
    '{1'b0, 31'd0, FUNC_GENERATE, KEY_ONES,                31'd100,  1'b1, 5'd0,  1'b1},
    '{1'b0, 31'd0, FUNC_COUNT,    64'd0,                   31'd100,  1'b1, 5'd16, 1'b0},
    // longest lifetime: renew the newest zero key, then purge the rest
    '{1'b1, TIME_MAX, FUNC_RENEW, 64'd0,                   31'd100,  1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_COUNT,    KEY_ONES,                31'd101,  1'b0, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_COUNT,    64'd0,                   TIME_MAX, 1'b0, 5'd0,  1'b0},
    // zero lifetime: token born expired, renew misses, count purges it
    '{1'b1, 31'd0, FUNC_GENERATE, 64'd1,                   31'd0,    1'b1, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_RENEW,    64'd1,                   31'd0,    1'b0, 5'd0,  1'b0},
    '{1'b0, 31'd0, FUNC_COUNT,    64'd0,                   31'd0,    1'b0, 5'd0,  1'b0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_BYTES_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_BYTES_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [TIME_W-1:0]      cfg_wdata_i;

  // Predictor state
  logic [KEY_BITS-1:0]    tok_key [TABLE_DEPTH];
  logic [EXP_W-1:0]       tok_expiry [TABLE_DEPTH];
  int                     tok_fill;
  logic [TIME_W-1:0]      lifetime;

  result_t                pending_results [$];
  int                     n_errors;
  int                     n_results;
  bit                     send_burst;
  bit                     recv_burst;

  ttl_token_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predict the result of one request and update the table copy
  function automatic result_t apply_token_op(logic [FUNC_W-1:0] op,
                                             logic [TOKEN_W-1:0] key,
                                             logic [TIME_W-1:0] now);
    logic [EXP_W-1:0] fresh;
    logic [EXP_W-1:0] now_x;
    result_t          res;
    int               live;
    bit               hit;
    fresh = {1'b0, now} + {1'b0, lifetime};
    now_x = {1'b0, now};
    res   = '0;
    live  = 0;
    hit   = 1'b0;
    case (op)
      FUNC_GENERATE: begin
        if (tok_fill >= TABLE_DEPTH) begin
          res.status = 1'b1;
        end else begin
          tok_key[tok_fill]    = key[KEY_BITS-1:0];
          tok_expiry[tok_fill] = fresh;
          tok_fill++;
        end
      end
      FUNC_RENEW: begin
        // newest live entry with this key wins
        for (int i = tok_fill - 1; i >= 0; i--) begin
          if (!hit && tok_key[i] == key[KEY_BITS-1:0] && tok_expiry[i] > now_x) begin
            tok_expiry[i] = fresh;
            hit = 1'b1;
          end
        end
      end
      FUNC_COUNT: begin
        // compact survivors towards slot 0
        for (int i = 0; i < tok_fill; i++) begin
          if (tok_expiry[i] > now_x) begin
            tok_key[live]    = tok_key[i];
            tok_expiry[live] = tok_expiry[i];
            live++;
          end
        end
        tok_fill       = live;
        res.live_count = live[LIVE_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [IN_BYTES_W-1:0] pack_request(logic [FUNC_W-1:0] op,
                                                         logic [TOKEN_W-1:0] key,
                                                         logic [TIME_W-1:0] now);
    logic [IN_BYTES_W-1:0] d;
    d = '0;
    d[FUNC_W-1:0]                = op;
    d[FUNC_W +: TOKEN_W]         = key;
    d[FUNC_W + TOKEN_W +: TIME_W] = now;
    return d;
  endfunction

  // Offer one item after a random gap; record its expectation on accept
  task automatic send_item(input logic [FUNC_W-1:0] op, input logic [TOKEN_W-1:0] key,
                           input logic [TIME_W-1:0] now, input bit typed,
                           input result_t typed_res);
    int      gap;
    result_t predicted;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_request(op, key, now);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_token_op(op, key, now);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Lifetime changes only with the block idle
  task automatic set_lifetime(input logic [TIME_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (LATENCY_SLACK) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lifetime     = value;
  endtask

  // Result side: random stalls, one long hold-off, field checks
  initial begin
    int      stall;
    bit      held;
    result_t got;
    result_t want;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 4);
      if (!held && n_results >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[OUT_W-1:0];
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: live_count %0d status %0d",
               got.live_count, got.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
          n_errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          n_errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases
  initial begin
    logic [FUNC_W-1:0]  op;
    logic [TOKEN_W-1:0] key;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  clock_now;
    logic [TOKEN_W-1:0] key_pool [8];
    logic [TIME_W-1:0]  phase_life [N_PHASES];
    result_t            row_res;
    int                 pick;
    int                 sent;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    tok_fill      = 0;
    lifetime      = 31'd1;
    n_errors      = 0;
    n_results     = 0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].lifetime_wr) set_lifetime(DIRECTED_ROWS[r].lifetime_val);
      row_res.live_count = DIRECTED_ROWS[r].live;
      row_res.status     = DIRECTED_ROWS[r].status;
      send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].now,
                DIRECTED_ROWS[r].typed, row_res);
    end

    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (int k = 2; k < 8; k++) key_pool[k] = {$urandom, $urandom};

    phase_life[0] = 31'd1;
    phase_life[1] = TIME_W'($urandom_range(2, 30));
    phase_life[2] = TIME_MAX;
    phase_life[3] = 31'd0;
    phase_life[4] = TIME_W'($urandom);
    phase_life[5] = TIME_W'($urandom_range(3, 10));

    for (int p = 0; p < N_PHASES; p++) begin
      set_lifetime(phase_life[p]);
      // the longest lifetime runs near the top of the time range
      clock_now = (p == 2) ? TIME_MAX - 31'd500 : TIME_W'($urandom_range(0, 1000));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 1 && sent == 40) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
        if ($urandom_range(0, 9) == 0) begin
          // noise: anything goes, time may jump backwards
          op  = FUNC_W'($urandom_range(0, 3));
          key = {$urandom, $urandom};
          now = TIME_W'($urandom);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45)      op = FUNC_GENERATE;
          else if (pick < 70) op = FUNC_RENEW;
          else if (pick < 97) op = FUNC_COUNT;
          else                op = FUNC_SPARE;
          key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, 7)]
                                            : {$urandom, $urandom};
          if (clock_now > TIME_MAX - 31'd3) clock_now = TIME_MAX;
          else clock_now = clock_now + TIME_W'($urandom_range(0, 3));
          now = clock_now;
        end
        send_item(op, key, now, 1'b0, '0);
        if (op != FUNC_SPARE) sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (LATENCY_SLACK) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_ttl_token_table: done, clean");
    end else begin
      $display("tb_ttl_token_table: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb_ttl_token_table: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ttl_pkg.sv
rtl/ttl_ram.sv
rtl/ttl_engine.sv
rtl/ttl_token_table.sv
rtl/ttl_checker.sv
tb/tb_ttl_token_table.sv
